>>> sv/mf3_pkg.sv
// Shared types and constants for the 3x3 median filter core.
// No dependencies; imported by mf3_median9 and median_filter_3x3_core.
package mf3_pkg;

    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
    localparam int unsigned WIDTH_W    = 11;
    localparam int unsigned HEIGHT_W   = 13;
    localparam int unsigned ROW_W      = 13;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned CFG_DATA_W = 13;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef t_pixel [8:0]     t_win9;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

endpackage

>>> sv/mf3_median9.sv
// Median-of-nine selection network (19 compare-exchange operations).
// Depends on mf3_pkg for the pixel and window types.
module mf3_median9 (
    input  mf3_pkg::t_win9  i_win,
    output mf3_pkg::t_pixel o_median
);
    import mf3_pkg::*;

    localparam int unsigned N_OPS = 19;
    localparam int unsigned OP_A [N_OPS] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0,
                                             5, 4, 3, 1, 2, 4, 4, 6, 4};
    localparam int unsigned OP_B [N_OPS] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3,
                                             8, 7, 6, 4, 5, 7, 2, 4, 2};

    always_comb begin
        t_pixel v [9];
        t_pixel t;
        t = '0;
        for (int i = 0; i < 9; i++) begin
            v[i] = i_win[i];
        end
        // each step leaves the smaller value at OP_A and the larger at OP_B
        for (int k = 0; k < N_OPS; k++) begin
            if (v[OP_A[k]] > v[OP_B[k]]) begin
                t          = v[OP_A[k]];
                v[OP_A[k]] = v[OP_B[k]];
                v[OP_B[k]] = t;
            end
        end
        o_median = v[4];
    end

endmodule

>>> sv/median_filter_3x3_core.sv
// Streaming 3x3 median filter: two line stores, a 3x3 window and a result register.
// Depends on mf3_pkg and mf3_median9.
// Throughput: one beat per cycle unless i_out_ready holds the output; a result beat leaves
// after the input beat that completes its window, through the store read stage, then
// window/median into the output register. Results lag the image by one row plus one pixel.
// Reset (synchronous, active low) clears counters, window and valids; sizes go to 512.
module median_filter_3x3_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  mf3_pkg::t_cfg_index               i_cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  mf3_pkg::t_pixel                   i_pixel_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mf3_pkg::t_pixel                   o_pixel_out,
    output logic                              o_frame_last
);
    import mf3_pkg::*;

    localparam logic [ROW_W-1:0] ROW_CAP = '1;

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
        return (r < ROW_CAP) ? r + 1'b1 : ROW_CAP;
    endfunction

    // configuration
    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;

    // counters
    logic [ADDR_W-1:0] r_in_col, r_out_col, n_in_col, n_out_col;
    logic [ROW_W-1:0]  r_in_row, r_out_row, n_in_row, n_out_row;
    logic [ADDR_W-1:0] in_col_eff, out_col_eff;
    logic [ROW_W-1:0]  in_row_eff, out_row_eff;
    logic [WIDTH_W-1:0] in_col_p1, out_col_p1;
    logic draining, accept, go, emit, border, last;

    // line stores
    t_pixel mem_up  [MAX_WIDTH];
    t_pixel mem_mid [MAX_WIDTH];
    t_pixel r_up_rd, r_mid_rd;
    logic   r_fwd;
    t_pixel r_fwd_up, r_fwd_mid;

    // store read stage
    logic              r_s1_valid, r_s1_emit, r_s1_border, r_s1_last;
    t_pixel            r_s1_pix;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              s1_adv;
    t_pixel            up_val, mid_val;

    // window and result
    t_pixel r_win [3][3];
    t_win9  win_new;
    t_pixel median;
    logic   r_out_valid, r_out_last;
    t_pixel r_out_pixel;

    assign w = (r_image_width < WIDTH_W'(3)) ? WIDTH_W'(3) :
               (r_image_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : r_image_width;
    assign h = (r_image_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) :
               (r_image_height > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) :
               r_image_height;

    assign s1_adv     = r_s1_valid && (!r_s1_emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        in_col_eff  = r_in_col;
        in_row_eff  = r_in_row;
        out_col_eff = r_out_col;
        out_row_eff = r_out_row;
        if ({1'b0, r_in_col} >= w) begin
            in_col_eff = '0;
            in_row_eff = row_inc(r_in_row);
        end
        if ({1'b0, r_out_col} >= w) begin
            out_col_eff = '0;
            out_row_eff = row_inc(r_out_row);
        end

        draining = ({3'b0, in_row_eff[ROW_W-1:0]} >= {3'b0, h});
        go       = accept && (!i_mode || draining);
        emit     = (in_row_eff >= ROW_W'(2)) ||
                   ((in_row_eff == ROW_W'(1)) && (in_col_eff != '0));

        in_col_p1 = {1'b0, in_col_eff} + 1'b1;
        if (in_col_p1 >= w) begin
            n_in_col = '0;
            n_in_row = row_inc(in_row_eff);
        end else begin
            n_in_col = in_col_p1[ADDR_W-1:0];
            n_in_row = in_row_eff;
        end

        border = (out_row_eff == '0) || (out_row_eff >= ROW_W'(h - 1'b1)) ||
                 (out_col_eff == '0) || ({1'b0, out_col_eff} >= w - 1'b1);
        last   = (out_row_eff >= ROW_W'(h - 1'b1)) && ({1'b0, out_col_eff} >= w - 1'b1);

        out_col_p1 = {1'b0, out_col_eff} + 1'b1;
        n_out_col  = out_col_eff;
        n_out_row  = out_row_eff;
        if (emit) begin
            if (out_col_p1 >= w) begin
                n_out_col = '0;
                n_out_row = row_inc(out_row_eff);
            end else begin
                n_out_col = out_col_p1[ADDR_W-1:0];
            end
        end
        if (emit && last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_W'(512);
            r_image_height <= HEIGHT_W'(512);
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (go) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end else if (accept) begin
                // a dropped beat (i_mode set, not draining) still commits the column wrap
                r_in_col  <= in_col_eff;
                r_in_row  <= in_row_eff;
                r_out_col <= out_col_eff;
                r_out_row <= out_row_eff;
            end
            if (go) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // stage payload; a write to the same column in this edge is forwarded
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1_emit   <= emit;
            r_s1_border <= border;
            r_s1_last   <= last;
            r_s1_pix    <= draining ? '0 : i_pixel_in;
            r_s1_addr   <= in_col_eff;
            r_fwd       <= s1_adv && (r_s1_addr == in_col_eff);
            r_fwd_up    <= mid_val;
            r_fwd_mid   <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_up_rd  <= mem_up[in_col_eff];
            r_mid_rd <= mem_mid[in_col_eff];
        end
        if (s1_adv) begin
            mem_up[r_s1_addr]  <= mid_val;
            mem_mid[r_s1_addr] <= r_s1_pix;
        end
    end

    assign up_val  = r_fwd ? r_fwd_up  : r_up_rd;
    assign mid_val = r_fwd ? r_fwd_mid : r_mid_rd;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_new[r*3]     = r_win[r][1];
            win_new[r*3 + 1] = r_win[r][2];
        end
        win_new[2] = up_val;
        win_new[5] = mid_val;
        win_new[8] = r_s1_pix;
    end

    mf3_median9 u_median9 (
        .i_win    (win_new),
        .o_median (median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_win[r][c] <= win_new[r*3 + c];
                    end
                end
            end
            if (s1_adv && r_s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_out_pixel <= r_s1_border ? win_new[4] : median;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pixel;
    assign o_frame_last = r_out_last;

endmodule
